FILE: hw/rtl/shs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int BLOCK_BYTES  = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int ROUNDS       = 64;

    typedef logic [31:0] word_t;
    typedef word_t [BLOCK_WORDS-1:0] block_t;

    typedef struct packed {
        block_t words;
        logic   last_blk;
    } job_t;

    localparam word_t HASH_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

FILE: hw/rtl/shs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_front
// Byte intake: packs message bytes into a block, counts the length and
// builds the padding blocks at the end of a message.
// ----------------------------------------------------------------------------
module shs_front
    import shs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    input  logic       s_tlast,
    output logic       push_valid,
    output job_t       push_job,
    input  logic       q_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_PAD2 = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [63:0] count_reg, count_next;
    word_t       blk_reg [BLOCK_WORDS];

    logic [5:0]  pos;
    logic        accept;
    logic        len_fits;
    logic        second;
    logic [63:0] bit_len;
    block_t      full_blk;
    block_t      pad_blk;

    assign pos      = count_reg[5:0];
    assign s_tready = (state_reg == ST_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign second   = (state_reg == ST_PAD2);
    assign len_fits = second || (pos < 6'd56);
    assign bit_len  = {count_reg[60:0], 3'b000};

    always_comb begin
        for (int w = 0; w < BLOCK_WORDS; w++) begin
            full_blk[w] = blk_reg[w];
            for (int b = 0; b < 4; b++) begin
                if (!second && (6'(4*w+b) < pos)) begin
                    pad_blk[w][8*(3-b) +: 8] = blk_reg[w][8*(3-b) +: 8];
                end else if (!second && (6'(4*w+b) == pos)) begin
                    pad_blk[w][8*(3-b) +: 8] = PAD_MARK;
                end else begin
                    pad_blk[w][8*(3-b) +: 8] = 8'h00;
                end
            end
        end
        full_blk[BLOCK_WORDS-1][7:0] = s_tdata;
        if (len_fits) begin
            pad_blk[BLOCK_WORDS-2] = bit_len[63:32];
            pad_blk[BLOCK_WORDS-1] = bit_len[31:0];
        end
    end

    always_comb begin
        if (state_reg == ST_IDLE) begin
            push_valid        = accept && s_tuser[0] && (pos == 6'd63);
            push_job.words    = full_blk;
            push_job.last_blk = 1'b0;
        end else begin
            push_valid        = !q_full;
            push_job.words    = pad_blk;
            push_job.last_blk = len_fits;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        count_next = count_reg + 64'd1;
                    end
                    if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!q_full) begin
                    if (len_fits) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_PAD2;
                    end
                end
            end
            ST_PAD2: begin
                if (!q_full) begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser[0]) begin
            blk_reg[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= s_tdata;
        end
    end

endmodule

FILE: hw/rtl/shs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_queue
// Two-entry block queue between the byte intake and the compression core.
// ----------------------------------------------------------------------------
module shs_queue
    import shs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic q_full,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push, do_pop;

    assign q_full    = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !q_full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/shs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_core
// Compression core: one SHA-256 round per cycle, chain update, and digest
// output after the final block of a message.
// ----------------------------------------------------------------------------
module shs_core
    import shs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    input  job_t        pop_job,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

    logic [1:0] state_reg;
    logic [5:0] round_reg;
    logic       last_reg;
    logic [2:0] idx_reg;
    word_t      chain_reg [DIGEST_WORDS];
    word_t      var_reg [DIGEST_WORDS];
    word_t      win_reg [BLOCK_WORDS];

    word_t      t1, t2, w_new, ch, maj;

    assign pop = (state_reg == ST_IDLE) && pop_valid;

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = chain_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == LAST_IDX);

    always_comb begin
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);
        t1    = var_reg[7] + big_sigma1(var_reg[4]) + ch + ROUND_K[round_reg] + win_reg[0];
        t2    = big_sigma0(var_reg[0]) + maj;
        w_new = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1]) + win_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_reg[i] <= HASH_INIT[i];
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(ROUNDS - 1)) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        chain_reg[i] <= chain_reg[i] + var_reg[i];
                    end
                    idx_reg   <= '0;
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (idx_reg == LAST_IDX) begin
                            for (int i = 0; i < DIGEST_WORDS; i++) begin
                                chain_reg[i] <= HASH_INIT[i];
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            last_reg <= pop_job.last_blk;
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                win_reg[i] <= pop_job.words[i];
            end
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                var_reg[i] <= chain_reg[i];
            end
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLOCK_WORDS-1] <= w_new;
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

endmodule

FILE: hw/rtl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 of a byte stream, digest out as eight 32-bit words.
//
// Input channel (s_): one item per message byte. s_tdata is the byte,
// s_tuser[0] says the byte belongs to the message, s_tlast marks the last
// item of a message; an item with s_tuser[0] low and s_tlast high ends a
// message without adding a byte, so the empty message can be hashed.
// Output channel (m_): eight items per message, digest words H0..H7;
// m_tuser is the word index, m_tlast is high on the eighth word.
// Compression: the core runs one round per cycle; it takes a new 64-byte
// block only after the last one is chained and, at a message end, sent out.
// A two-block queue between the byte intake and the core keeps bytes flowing
// while a block compresses. Padding takes one or two further blocks;
// m_tvalid rises once the final padding block has gone through the queue,
// the rounds and the chain update, behind any blocks still ahead of it.
// Reset (aresetn low, synchronous) empties the queue and restores the
// initial hash values. While the receiver stalls the digest word holds;
// the intake keeps taking bytes until the queue is full.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    logic push_valid;
    job_t push_job;
    logic q_full;
    logic pop;
    logic pop_valid;
    job_t pop_job;

    shs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_full     (q_full)
    );

    shs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_full     (q_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    shs_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: hw/rtl/shs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks of the hasher's digest output, bound to the top level.
// ----------------------------------------------------------------------------
module shs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("digest item changed while stalled");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("tlast not on the eighth digest word");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser == ($past(m_tuser) + 3'd1))))
        else $error("digest words not back to back in order");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: dv/sha256_stream_hasher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_tb
// Streams byte messages into the hasher and checks every digest word.
//
// A SHA-256 model inside the bench folds each accepted input item and queues
// the eight digest words each finished message should produce. The checker
// compares every accepted output item against the oldest queued word. Runs a
// short directed set (empty message, end with and without a byte, byte
// extremes, ignored items), then random messages across four idling phases.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 16;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    logic [63:0]  msg_len;
    digest_word_t digest_q [$];

    int fail_count;
    int items_sent;
    int src_idle_pct;
    int snk_stall_pct;
    int quiet_cycles;

    sha256_stream_hasher_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1, wt, x15, x2;
        int r;
        for (r = 0; r < 16; r++) w[r] = msg_block[r];
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                x15 = w[(r - 15) & 15];
                x2  = w[(r - 2) & 15];
                s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                wt  = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
                w[r & 15] = wt;
            end
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[r] + wt;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void put_block_byte(input int pos, input logic [7:0] b);
        msg_block[pos >> 2][8 * (3 - (pos & 3)) +: 8] = b;
    endfunction

    function automatic void restart_digest();
        int i;
        for (i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
        msg_len = '0;
    endfunction

    // Fold one accepted input item; queue the digest when the message ends.
    function automatic void fold_item(input logic [7:0] data, input bit has, input bit eom);
        logic [63:0]  bit_len;
        digest_word_t dw;
        int pos;
        int i;
        if (has) begin
            pos = int'(msg_len[5:0]);
            put_block_byte(pos, data);
            msg_len++;
            if (pos == 63) sha_compress();
        end
        if (eom) begin
            bit_len = msg_len << 3;
            pos = int'(msg_len[5:0]);
            put_block_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    put_block_byte(pos, 8'h00);
                    pos++;
                end
                sha_compress();
                pos = 0;
            end
            while (pos < 56) begin
                put_block_byte(pos, 8'h00);
                pos++;
            end
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            sha_compress();
            for (i = 0; i < 8; i++) begin
                dw.word  = hash_state[i];
                dw.index = 3'(i);
                dw.last  = (i == 7);
                digest_q = {digest_q, dw};
            end
            restart_digest();
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input bit has, input bit eom);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        fold_item(data, has, eom);
        if (has || eom) items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        int i;
        for (i = 0; i < len; i++) begin
            while ($urandom_range(99) < noise_pct)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!(end_on_byte && len > 0))
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic wait_digests_drained();
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_end_on_byte();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
    endtask

    task automatic test_end_without_byte();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
    endtask

    task automatic test_ignored_items();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n);
        int  start;
        int  len;
        bit  paused;
        start         = items_sent;
        paused        = 1'b0;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (items_sent - start < n) begin
            if (!paused && (items_sent - start >= n / 2)) begin
                wait_digests_drained();
                paused = 1'b1;
            end
            // Mostly short messages; some straddle the one- and two-block padding edges.
            len = ($urandom_range(4) == 0) ? $urandom_range(52, 70) : $urandom_range(0, 10);
            send_message(len, 1'($urandom_range(1)), 8);
        end
        wait_digests_drained();
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        digest_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected digest item word=%08h index=%0d last=%0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                exp_w = digest_q.pop_front();
                if (m_tdata !== exp_w.word || m_tuser !== exp_w.index
                        || m_tlast !== exp_w.last) begin
                    fail_count++;
                    $display("%0t: expected word=%08h index=%0d last=%0b, got word=%08h index=%0d last=%0b",
                             $time, exp_w.word, exp_w.index, exp_w.last,
                             m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
            $display("sha256_stream_hasher_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        restart_digest();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_message();
        test_end_on_byte();
        test_end_without_byte();
        test_ignored_items();
        wait_digests_drained();

        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(83, 0, PHASE_ITEMS);
        test_random_traffic(0, 83, PHASE_ITEMS);
        test_random_traffic(7, 7, PHASE_ITEMS);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && digest_q.size() == 0) begin
            $display("sha256_stream_hasher_top: match");
        end else begin
            $display("sha256_stream_hasher_top: mismatch");
        end
        $finish;
    end

endmodule
